/* hdl/btd256_pkg.sv */
// Shared types, constants and the digit doubling function of the 256-bit binary to BCD converter.
// Used by btd256_ctrl, btd256_dp and binary_to_decimal_256; depends on nothing else.
`timescale 1ns / 1ps

package btd256_pkg;

   localparam int INPUT_BITS_DEF       = 256;
   localparam int DECIMAL_DIGITS_DEF   = 78;
   localparam int DIGITS_PER_CHUNK_DEF = 16;

   localparam int WORD_W      = 64;
   localparam int NUM_WORDS   = 4;
   localparam int IN_TDATA_W  = WORD_W * NUM_WORDS;
   localparam int CHUNK_W     = 64;
   localparam int INDEX_W     = 3;
   localparam int COUNT_W     = 7;
   localparam int OUT_TDATA_W = 80;
   localparam int OUT_PAD_W   = OUT_TDATA_W - CHUNK_W - INDEX_W - COUNT_W;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONV,
      ST_SCAN,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic load;
      logic shift;
      logic scan;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic bit_last;
      logic scan_done;
      logic chunk_last;
      logic out_free;
   } status_type;

   // Doubles one BCD digit and adds the incoming carry, modulo ten.
   function automatic logic [3:0] dbl_digit(input logic [3:0] digit, input logic carry);
      logic [4:0] sum;
      sum = {digit, carry};
      if (digit >= 4'd5) begin
         sum = sum - 5'd10;
      end
      return sum[3:0];
   endfunction

endpackage

/* hdl/binary_to_decimal_256.sv */
// Top level of the 256-bit binary to BCD converter (shift-and-double).
// Depends on btd256_pkg, btd256_ctrl and btd256_dp.
//
// The request channel takes one beat holding the binary value as four 64-bit words.
// The response channel returns one beat per BCD chunk, most significant chunk first,
// five beats with the default sizes; rsp_tlast marks the final chunk of a conversion.
// Each response beat carries sixteen BCD digits, the chunk position and the count of
// significant digits after trimming leading zeros (at least one).
// After acceptance the shift loop doubles the digit register once per input bit, MSB first.
// The trim scan then checks the top digit and walks the digit count down only if the value
// overflowed the digit register, which cannot happen with the default sizes.
// Chunks then leave one per cycle while the receiver is ready, through a single output register.
// When the receiver stalls, the output register holds its beat and the chunk sequence
// waits; req_tready rises again as soon as the last chunk is loaded into that register.
// Reset is synchronous and empties the output register and returns the sequencer to idle.
`timescale 1ns / 1ps

module binary_to_decimal_256 #(
   parameter int INPUT_BITS       = btd256_pkg::INPUT_BITS_DEF,
   parameter int DECIMAL_DIGITS   = btd256_pkg::DECIMAL_DIGITS_DEF,
   parameter int DIGITS_PER_CHUNK = btd256_pkg::DIGITS_PER_CHUNK_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // Fields from bit 0: word_0, word_1, word_2, word_3.
   input  logic [btd256_pkg::IN_TDATA_W-1:0]  req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // Fields from bit 0: bcd_chunk, chunk_index, digit_count, zero padding.
   output logic [btd256_pkg::OUT_TDATA_W-1:0] rsp_tdata,
   output logic                               rsp_tlast
);

   btd256_pkg::cmd_type    cmd;
   btd256_pkg::status_type status;

   btd256_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   btd256_dp #(
      .INPUT_BITS       (INPUT_BITS),
      .DECIMAL_DIGITS   (DECIMAL_DIGITS),
      .DIGITS_PER_CHUNK (DIGITS_PER_CHUNK)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .cmd        (cmd),
      .status     (status),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

/* hdl/btd256_ctrl.sv */
// Sequencer of the binary to BCD converter: accept, shift-and-double, trim scan, chunk output.
// Depends on btd256_pkg; drives the command bundle of btd256_dp.
`timescale 1ns / 1ps

module btd256_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  btd256_pkg::status_type status,
   output btd256_pkg::cmd_type    cmd
);

   btd256_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= btd256_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         btd256_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               state_in = btd256_pkg::ST_CONV;
            end
         end
         btd256_pkg::ST_CONV: begin
            if (status.bit_last) begin
               state_in = btd256_pkg::ST_SCAN;
            end
         end
         btd256_pkg::ST_SCAN: begin
            if (status.scan_done) begin
               state_in = btd256_pkg::ST_OUT;
            end
         end
         btd256_pkg::ST_OUT: begin
            if (status.out_free && status.chunk_last) begin
               state_in = btd256_pkg::ST_IDLE;
            end
         end
         default: state_in = btd256_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      cmd        = '0;
      unique case (state_ff)
         btd256_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         btd256_pkg::ST_CONV: begin
            cmd.shift = 1'b1;
         end
         btd256_pkg::ST_SCAN: begin
            cmd.scan = 1'b1;
         end
         btd256_pkg::ST_OUT: begin
            cmd.emit = status.out_free;
         end
         default: cmd = '0;
      endcase
   end

endmodule

/* hdl/btd256_dp.sv */
// Datapath of the binary to BCD converter: shift register, digit register, counters, output stage.
// Depends on btd256_pkg; commanded by btd256_ctrl.
`timescale 1ns / 1ps

module btd256_dp #(
   parameter int INPUT_BITS       = btd256_pkg::INPUT_BITS_DEF,
   parameter int DECIMAL_DIGITS   = btd256_pkg::DECIMAL_DIGITS_DEF,
   parameter int DIGITS_PER_CHUNK = btd256_pkg::DIGITS_PER_CHUNK_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic [btd256_pkg::IN_TDATA_W-1:0]     req_tdata,
   input  btd256_pkg::cmd_type                   cmd,
   output btd256_pkg::status_type                status,
   output logic [btd256_pkg::OUT_TDATA_W-1:0]    rsp_tdata,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic                                  rsp_tlast
);

   localparam int DIG_W      = DECIMAL_DIGITS * 4;
   localparam int NUM_CHUNKS = (DECIMAL_DIGITS + DIGITS_PER_CHUNK - 1) / DIGITS_PER_CHUNK;
   localparam int CHK_W      = DIGITS_PER_CHUNK * 4;
   localparam int PAD_W      = NUM_CHUNKS * CHK_W;
   localparam int SIG_W      = $clog2(DECIMAL_DIGITS + 1);
   localparam int IDX_W      = $clog2(DECIMAL_DIGITS);
   localparam int BIT_W      = $clog2(INPUT_BITS + 1);
   localparam int CNT_W      = $clog2(NUM_CHUNKS + 1);

   logic [INPUT_BITS-1:0]              sh_ff, sh_in;
   logic [DIG_W-1:0]                   dig_ff, dig_in;
   logic [SIG_W-1:0]                   sig_ff, sig_in;
   logic [BIT_W-1:0]                   bcnt_ff, bcnt_in;
   logic [CNT_W-1:0]                   cnt_ff, cnt_in;
   logic [btd256_pkg::OUT_TDATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                               rsp_last_ff, rsp_last_in;
   logic                               rsp_valid_ff, rsp_valid_in;

   logic [DIG_W-1:0] dbl;
   logic [IDX_W-1:0] top_idx;
   logic [3:0]       top_d;
   logic [PAD_W-1:0] padded;
   logic [CHK_W-1:0] chunk_sel;

   // Doubling carries only on the old digit value, so every digit updates independently.
   always_comb begin
      dbl[3:0] = btd256_pkg::dbl_digit(dig_ff[3:0], sh_ff[INPUT_BITS-1]);
      for (int j = 1; j < DECIMAL_DIGITS; j++) begin
         dbl[j*4 +: 4] = btd256_pkg::dbl_digit(dig_ff[j*4 +: 4], dig_ff[(j-1)*4 +: 4] >= 4'd5);
      end
   end

   // The significant digit count tracks the highest nonzero digit; after a dropped carry
   // the scan walks it down to the true top digit.
   assign top_idx = IDX_W'(sig_ff - SIG_W'(1));
   assign top_d   = dig_ff[top_idx*4 +: 4];
   assign padded  = PAD_W'(dig_ff);

   always_comb begin
      chunk_sel = '0;
      for (int k = 0; k < NUM_CHUNKS; k++) begin
         if (cnt_ff == CNT_W'(k)) begin
            chunk_sel = padded[(NUM_CHUNKS-1-k)*CHK_W +: CHK_W];
         end
      end
   end

   always_comb begin
      sh_in        = sh_ff;
      dig_in       = dig_ff;
      sig_in       = sig_ff;
      bcnt_in      = bcnt_ff;
      cnt_in       = cnt_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.load) begin
         sh_in   = req_tdata[INPUT_BITS-1:0];
         dig_in  = '0;
         sig_in  = SIG_W'(1);
         bcnt_in = '0;
         cnt_in  = '0;
      end
      if (cmd.shift) begin
         sh_in   = {sh_ff[INPUT_BITS-2:0], 1'b0};
         dig_in  = dbl;
         bcnt_in = bcnt_ff + BIT_W'(1);
         if (top_d >= 4'd5 && sig_ff != SIG_W'(DECIMAL_DIGITS)) begin
            sig_in = sig_ff + SIG_W'(1);
         end
      end
      if (cmd.scan) begin
         if (top_d == 4'd0 && sig_ff != SIG_W'(1)) begin
            sig_in = sig_ff - SIG_W'(1);
         end
      end
      if (cmd.emit) begin
         rsp_data_in  = {{btd256_pkg::OUT_PAD_W{1'b0}},
                         btd256_pkg::COUNT_W'(sig_ff),
                         btd256_pkg::INDEX_W'(cnt_ff),
                         btd256_pkg::CHUNK_W'(chunk_sel)};
         rsp_last_in  = (cnt_ff == CNT_W'(NUM_CHUNKS - 1));
         rsp_valid_in = 1'b1;
         cnt_in       = cnt_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sig_ff       <= SIG_W'(1);
         bcnt_ff      <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sig_ff       <= sig_in;
         bcnt_ff      <= bcnt_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sh_ff       <= sh_in;
      dig_ff      <= dig_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign status.bit_last   = (bcnt_ff == BIT_W'(INPUT_BITS - 1));
   assign status.scan_done  = !(top_d == 4'd0 && sig_ff != SIG_W'(1));
   assign status.chunk_last = (cnt_ff == CNT_W'(NUM_CHUNKS - 1));
   assign status.out_free   = !rsp_valid_ff || rsp_tready;

   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

/* test/binary_to_decimal_256_tb.sv */
// Self-checking testbench for the 256-bit binary to BCD converter binary_to_decimal_256.
// Predicts the five BCD chunk beats of every accepted request and checks them in order.
// Depends on btd256_pkg and the RTL of binary_to_decimal_256.
`timescale 1ns / 1ps

module binary_to_decimal_256_tb;

   import btd256_pkg::*;

   localparam int DIGITS      = DECIMAL_DIGITS_DEF;
   localparam int PER_CHUNK   = DIGITS_PER_CHUNK_DEF;
   localparam int CHUNKS      = (DIGITS + PER_CHUNK - 1) / PER_CHUNK;
   localparam int PAD_DIGITS  = CHUNKS * PER_CHUNK;
   localparam int RANDOM_REQS = 410;

   typedef enum int {
      READY_ALWAYS,
      READY_RANDOM,
      READY_BURSTY
   } ready_style_type;

   typedef enum int {
      SHAPE_FULL,
      SHAPE_SHORT,
      SHAPE_SPARSE,
      SHAPE_TINY
   } value_shape_type;

   typedef struct packed {
      logic [CHUNK_W-1:0] bcd_chunk;
      logic [INDEX_W-1:0] chunk_index;
      logic [COUNT_W-1:0] digit_count;
      logic               last;
   } chunk_type;

   class bcd_scoreboard;
      chunk_type expected_chunks[$];
      int        mismatches = 0;

      function void note_request(logic [IN_TDATA_W-1:0] value);
         logic [3:0]              digits[DIGITS];
         logic [IN_TDATA_W-1:0]   bits;
         logic [PAD_DIGITS*4-1:0] padded;
         int                      carry;
         int                      sum;
         int                      lead;
         chunk_type               c;
         foreach (digits[j]) digits[j] = 4'd0;
         bits = value;
         for (int s = 0; s < IN_TDATA_W; s++) begin
            carry = int'(bits[IN_TDATA_W-1]);
            bits  = bits << 1;
            for (int j = DIGITS - 1; j >= 0; j--) begin
               sum   = 2 * digits[j] + carry;
               carry = (sum > 9) ? 1 : 0;
               if (carry != 0) begin
                  sum = sum - 10;
               end
               digits[j] = sum[3:0];
            end
         end
         lead = 0;
         while (lead < DIGITS - 1 && digits[lead] == 4'd0) lead++;
         padded = '0;
         for (int j = 0; j < DIGITS; j++) begin
            padded[(DIGITS - 1 - j) * 4 +: 4] = digits[j];
         end
         for (int k = 0; k < CHUNKS; k++) begin
            c.bcd_chunk   = padded[(CHUNKS - 1 - k) * CHUNK_W +: CHUNK_W];
            c.chunk_index = INDEX_W'(k);
            c.digit_count = COUNT_W'(DIGITS - lead);
            c.last        = (k == CHUNKS - 1);
            expected_chunks.push_back(c);
         end
      endfunction

      function void check_chunk(logic [OUT_TDATA_W-1:0] data, logic last_flag);
         chunk_type want;
         chunk_type got;
         got.bcd_chunk   = data[CHUNK_W-1:0];
         got.chunk_index = data[CHUNK_W +: INDEX_W];
         got.digit_count = data[CHUNK_W + INDEX_W +: COUNT_W];
         got.last        = last_flag;
         if (expected_chunks.size() == 0) begin
            $error("Unexpected response beat: bcd_chunk %h", got.bcd_chunk);
            mismatches++;
            return;
         end
         want = expected_chunks.pop_front();
         if (got.bcd_chunk !== want.bcd_chunk) begin
            $error("bcd_chunk: expected %h, actual %h", want.bcd_chunk, got.bcd_chunk);
            mismatches++;
         end
         if (got.chunk_index !== want.chunk_index) begin
            $error("chunk_index: expected %0d, actual %0d", want.chunk_index, got.chunk_index);
            mismatches++;
         end
         if (got.digit_count !== want.digit_count) begin
            $error("digit_count: expected %0d, actual %0d", want.digit_count, got.digit_count);
            mismatches++;
         end
         if (got.last !== want.last) begin
            $error("last: expected %0b, actual %0b", want.last, got.last);
            mismatches++;
         end
      endfunction

      function int pending();
         return expected_chunks.size();
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [IN_TDATA_W-1:0]  req_tdata;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [OUT_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tlast;

   bcd_scoreboard   sb;
   ready_style_type ready_style;
   int              style_left;
   int              hold_left;

   binary_to_decimal_256 u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always #10 clock = ~clock;

   task automatic send_value(input logic [IN_TDATA_W-1:0] value);
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      do @(posedge clock); while (!req_tready);
      sb.note_request(value);
   endtask

   task automatic idle_for(input int cycles);
      @(negedge clock);
      req_tvalid <= 1'b0;
      repeat (cycles - 1) @(negedge clock);
   endtask

   task automatic wait_drained();
      idle_for(1);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check_chunk(rsp_tdata, rsp_tlast);
      end
   end

   // The receiver switches between always ready, coin-flip stalls and long stalls.
   always @(negedge clock) begin
      if (!reset) begin
         if (style_left == 0) begin
            ready_style = ready_style_type'($urandom_range(READY_ALWAYS, READY_BURSTY));
            style_left  = $urandom_range(50, 1500);
         end else begin
            style_left = style_left - 1;
         end
         case (ready_style)
            READY_ALWAYS: begin
               rsp_tready <= 1'b1;
            end
            READY_RANDOM: begin
               rsp_tready <= 1'($urandom_range(0, 1));
            end
            default: begin
               if (hold_left == 0) begin
                  rsp_tready <= !rsp_tready;
                  hold_left = rsp_tready ? $urandom_range(1, 30) : $urandom_range(1, 4);
               end else begin
                  hold_left = hold_left - 1;
               end
            end
         endcase
      end
   end

   initial begin
      #40_000_000;
      $display("FAILED: results differ");
      $finish;
   end

   initial begin
      logic [IN_TDATA_W-1:0] value;
      logic [IN_TDATA_W-1:0] power;
      value_shape_type       shape;
      int                    sent;
      int                    burst;
      sb          = new;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      rsp_tready  = 1'b0;
      ready_style = READY_ALWAYS;
      style_left  = 0;
      hold_left   = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_value('0);
      send_value(256'd1);
      send_value(256'd9);
      send_value(256'd10);
      send_value(256'd99);
      send_value({IN_TDATA_W{1'b1}});
      send_value({1'b1, {(IN_TDATA_W-1){1'b0}}});
      send_value({(IN_TDATA_W/2){2'b01}});
      send_value({(IN_TDATA_W/2){2'b10}});
      for (int w = 0; w < NUM_WORDS; w++) begin
         value = '0;
         value[w * WORD_W +: WORD_W] = {WORD_W{1'b1}};
         send_value(value);
      end
      send_value(256'd1 << WORD_W);
      power = 256'd1;
      repeat (PER_CHUNK) power = power * 10;
      send_value(power - 1);
      send_value(power);
      repeat (DIGITS - 1 - PER_CHUNK) power = power * 10;
      send_value(power - 1);
      send_value(power);
      wait_drained();

      sent = 0;
      while (sent < RANDOM_REQS) begin
         burst = $urandom_range(1, 8);
         for (int b = 0; b < burst && sent < RANDOM_REQS; b++) begin
            for (int i = 0; i < IN_TDATA_W / 32; i++) value[i * 32 +: 32] = $urandom;
            shape = value_shape_type'($urandom_range(SHAPE_FULL, SHAPE_TINY));
            case (shape)
               SHAPE_SHORT: begin
                  value = value & ({IN_TDATA_W{1'b1}} >> $urandom_range(0, IN_TDATA_W - 1));
               end
               SHAPE_SPARSE: begin
                  value = '0;
                  repeat ($urandom_range(1, 4)) value[$urandom_range(0, IN_TDATA_W - 1)] = 1'b1;
               end
               SHAPE_TINY: begin
                  value = IN_TDATA_W'($urandom_range(0, 1000));
               end
               default: begin
               end
            endcase
            send_value(value);
            sent++;
         end
         if ($urandom_range(0, 29) == 0) begin
            wait_drained();
         end else if ($urandom_range(0, 3) != 0) begin
            idle_for($urandom_range(1, 300));
         end
      end
      wait_drained();
      repeat (20) @(posedge clock);

      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
